>>> src/rbst_pkg.sv
// ============================================================================
// Ray/box slab test package
// Shared types, constants and saturation helpers for the slab test core.
// ============================================================================
package rbst_pkg;

    // Signed Q16.16 value.
    typedef logic signed [31:0] q16_t;

    // One ray word on the input channel.
    typedef struct packed {
        q16_t origin_x;
        q16_t origin_y;
        q16_t origin_z;
        q16_t dir_x;
        q16_t dir_y;
        q16_t dir_z;
    } ray_t;

    // One result word on the output channel.
    typedef struct packed {
        logic hit;
        q16_t t_near;
        q16_t t_far;
    } result_t;

    // Word handed from the reciprocal front to the slab back end.
    typedef struct packed {
        q16_t [2:0] org;
        q16_t [2:0] inv;
    } qitem_t;

    // Queue status seen by both sides of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    // Reciprocal divider: one quotient bit per stage for 2^32 / |d|.
    localparam int RECIP_STEPS = 33;
    // Magnitude stage, the quotient steps and the final saturation stage.
    localparam int RECIP_LAT   = RECIP_STEPS + 2;

    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    // Saturate a 33-bit signed difference to Q16.16.
    function automatic q16_t sat33(input logic signed [32:0] v);
        q16_t r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturate a 48-bit signed value to Q16.16.
    function automatic q16_t sat48(input logic signed [47:0] v);
        q16_t r;
        if ((v[47:31] != '0) && (v[47:31] != '1)) begin
            r = v[47] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/rbst_recip.sv
// ============================================================================
// Reciprocal pipeline
// Computes 2^32 / d in Q16.16 with one restoring division step per stage,
// saturating the result and mapping a zero divisor to the largest value.
// ============================================================================
module rbst_recip (
    input  logic          aclk,
    input  logic          en,
    input  rbst_pkg::q16_t d,
    output rbst_pkg::q16_t recip
);
    import rbst_pkg::*;

    logic [31:0] den_reg  [0:RECIP_STEPS];
    logic [31:0] rem_reg  [0:RECIP_STEPS];
    logic [32:0] quo_reg  [0:RECIP_STEPS];
    logic        neg_reg  [0:RECIP_STEPS];
    logic        zero_reg [0:RECIP_STEPS];
    q16_t        recip_reg;
    q16_t        recip_next;
    logic [31:0] mag;
    logic        big;

    // Magnitude of the divisor; the most negative value maps to 2^31.
    assign mag = d[31] ? (~d + 32'd1) : d;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= mag;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= d[31];
            zero_reg[0] <= (d == '0);
        end
    end

    // One quotient bit per stage; the dividend has a single one at its top.
    for (genvar s = 0; s < RECIP_STEPS; s++) begin : g_step
        localparam logic NBIT = (s == 0);
        logic [32:0] shifted;
        logic [32:0] sub;
        logic        ge;

        assign shifted = {rem_reg[s], NBIT};
        assign sub     = shifted - {1'b0, den_reg[s]};
        assign ge      = (shifted >= {1'b0, den_reg[s]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= ge ? sub[31:0] : shifted[31:0];
                quo_reg[s+1]  <= {quo_reg[s][31:0], ge};
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    // Sign and saturation of the finished quotient.
    assign big = quo_reg[RECIP_STEPS][32] | quo_reg[RECIP_STEPS][31];

    always_comb begin
        if (zero_reg[RECIP_STEPS]) begin
            recip_next = Q_MAX;
        end else if (neg_reg[RECIP_STEPS]) begin
            recip_next = big ? Q_MIN : q16_t'(~quo_reg[RECIP_STEPS][31:0] + 32'd1);
        end else begin
            recip_next = big ? Q_MAX : q16_t'(quo_reg[RECIP_STEPS][31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            recip_reg <= recip_next;
        end
    end

    assign recip = recip_reg;

endmodule

>>> src/rbst_front.sv
// ============================================================================
// Front end
// Accepts ray words, forms the three reciprocals and pushes the origin and
// reciprocals into the queue. The whole front stalls when its last stage
// holds a word that the queue cannot take.
// ============================================================================
module rbst_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rbst_pkg::ray_t   s_data,
    input  rbst_pkg::qstat_t qstat,
    output logic             push,
    output rbst_pkg::qitem_t push_data
);
    import rbst_pkg::*;

    logic [RECIP_LAT-1:0] vld_reg;
    q16_t [2:0]           org_reg [0:RECIP_LAT-1];
    q16_t [2:0]           dir;
    q16_t [2:0]           inv;
    logic                 adv;

    assign adv     = !vld_reg[RECIP_LAT-1] || !qstat.full;
    assign s_ready = adv;
    assign push    = vld_reg[RECIP_LAT-1] && !qstat.full;

    assign dir[0] = s_data.dir_x;
    assign dir[1] = s_data.dir_y;
    assign dir[2] = s_data.dir_z;

    // One reciprocal pipeline per axis.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_recip u_recip (
            .aclk  (aclk),
            .en    (adv),
            .d     (dir[a]),
            .recip (inv[a])
        );
    end

    // Valid bits travel alongside the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[RECIP_LAT-2:0], s_valid};
        end
    end

    // The origin is carried to meet its reciprocals.
    always_ff @(posedge aclk) begin
        if (adv) begin
            org_reg[0] <= {s_data.origin_z, s_data.origin_y, s_data.origin_x};
            for (int i = 1; i < RECIP_LAT; i++) begin
                org_reg[i] <= org_reg[i-1];
            end
        end
    end

    assign push_data.org = org_reg[RECIP_LAT-1];
    assign push_data.inv = inv;

endmodule

>>> src/rbst_queue.sv
// ============================================================================
// Decoupling queue
// Small register queue between the reciprocal front and the slab back end.
// ============================================================================
module rbst_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rbst_pkg::qitem_t push_data,
    input  logic             pop,
    output rbst_pkg::qitem_t pop_data,
    output rbst_pkg::qstat_t qstat
);
    import rbst_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qitem_t        mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign qstat.full  = (cnt_reg == CW'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign pop_data    = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/rbst_back.sv
// ============================================================================
// Slab back end
// Forms the slab distances, the entry and exit distances and the hit flag,
// and holds the result word in the output register.
// ============================================================================
module rbst_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rbst_pkg::qstat_t      qstat,
    output logic                  pop,
    input  rbst_pkg::qitem_t      pop_data,
    input  rbst_pkg::q16_t [2:0]  box_lo,
    input  rbst_pkg::q16_t [2:0]  box_hi,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rbst_pkg::result_t     m_data
);
    import rbst_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0]     vld_reg;
    q16_t [2:0]         dlo_reg;
    q16_t [2:0]         dhi_reg;
    q16_t [2:0]         inv_reg;
    logic signed [63:0] plo_reg [0:2];
    logic signed [63:0] phi_reg [0:2];
    q16_t [2:0]         ta_reg;
    q16_t [2:0]         tb_reg;
    q16_t [2:0]         smin_reg;
    q16_t [2:0]         smax_reg;
    q16_t               enter_reg;
    q16_t               exit_reg;
    result_t            out_reg;
    q16_t               enter_next;
    q16_t               exit_next;
    logic               adv;

    assign adv = !vld_reg[NST-1] || m_ready;
    assign pop = adv && !qstat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                // Corner minus origin, saturated.
                dlo_reg[a] <= sat33(33'(box_lo[a]) - 33'(pop_data.org[a]));
                dhi_reg[a] <= sat33(33'(box_hi[a]) - 33'(pop_data.org[a]));
                inv_reg[a] <= pop_data.inv[a];
                // Full products.
                plo_reg[a] <= dlo_reg[a] * inv_reg[a];
                phi_reg[a] <= dhi_reg[a] * inv_reg[a];
                // Arithmetic shift floors, then saturate.
                ta_reg[a]  <= sat48(plo_reg[a][63:16]);
                tb_reg[a]  <= sat48(phi_reg[a][63:16]);
                // Order the two slab distances.
                smin_reg[a] <= (ta_reg[a] < tb_reg[a]) ? ta_reg[a] : tb_reg[a];
                smax_reg[a] <= (ta_reg[a] > tb_reg[a]) ? ta_reg[a] : tb_reg[a];
            end
            enter_reg <= enter_next;
            exit_reg  <= exit_next;
            // Hit decision.
            if ((exit_reg < 0) || (enter_reg > exit_reg)) begin
                out_reg.hit    <= 1'b0;
                out_reg.t_near <= exit_reg;
                out_reg.t_far  <= '0;
            end else begin
                out_reg.hit    <= 1'b1;
                out_reg.t_near <= enter_reg;
                out_reg.t_far  <= exit_reg;
            end
        end
    end

    // Largest entry and smallest exit across the three axes.
    always_comb begin
        enter_next = smin_reg[0];
        exit_next  = smax_reg[0];
        for (int a = 1; a < 3; a++) begin
            if (smin_reg[a] > enter_next) begin
                enter_next = smin_reg[a];
            end
            if (smax_reg[a] < exit_next) begin
                exit_next = smax_reg[a];
            end
        end
    end

    assign m_valid = vld_reg[NST-1];
    assign m_data  = out_reg;

endmodule

>>> src/ray_box_slab_test_core.sv
// ============================================================================
// Ray/box slab test core
// Tests streamed rays against an axis-aligned box held in six registers.
// ============================================================================
//
//  Channel | Ports                         | Word
//  --------+-------------------------------+---------------------------------
//  in      | s_valid s_ready s_data        | ray_t: origin and direction
//  out     | m_valid m_ready m_data        | result_t: hit, t_near, t_far
//  config  | cfg_valid cfg_ready cfg_index | box corner register, cfg_data
//
//  One word is accepted per cycle when the output side keeps up.
//  A ray passes through the reciprocal pipeline (one quotient bit per stage),
//  then through the queue and the back-end stages.
//  Reset clears valid bits, queue pointers and the box registers.
//  A stalled output holds the back end; the queue then fills and holds the
//  front, which drops s_ready. Configuration writes are always taken.
//
module ray_box_slab_test_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rbst_pkg::ray_t                        s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rbst_pkg::result_t                     m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  rbst_pkg::q16_t                        cfg_data
);
    import rbst_pkg::*;

    q16_t [2:0] lo_reg;
    q16_t [2:0] hi_reg;
    qstat_t     qstat;
    logic       push;
    logic       pop;
    qitem_t     push_data;
    qitem_t     pop_data;

    assign cfg_ready = 1'b1;

    // Box registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BOX_MIN_X: lo_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: lo_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: lo_reg[2] <= cfg_data;
                REG_BOX_MAX_X: hi_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: hi_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    rbst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    rbst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    rbst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .pop      (pop),
        .pop_data (pop_data),
        .box_lo   (lo_reg),
        .box_hi   (hi_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> src/rbst_checker.sv
// ============================================================================
// Slab test port checker
// Watches the top-level ports for output holding, reset and result sanity.
// ============================================================================
module rbst_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rbst_pkg::result_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready
);
    import rbst_pkg::*;

    // A stalled result word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Configuration writes are never refused.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // A miss reports zero exit distance.
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.t_far == '0)
        else $error("miss with nonzero t_far");

    // A hit has ordered distances and a non-negative exit distance.
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> (m_data.t_far >= 0) && (m_data.t_near <= m_data.t_far))
        else $error("hit with inconsistent distances");

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (.*);

>>> bench/ray_box_slab_test_core_tb.sv
// ----------------------------------------------------------------------------
// Ray/box slab test core testbench
// Streams rays through the core against several boxes and checks each
// result word against a slab-method model computed in Q16.16 here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_box_slab_test_core_tb;
    import rbst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    ray_t s_data;
    logic m_valid;
    logic m_ready;
    result_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    q16_t cfg_data;

    int cycles;

    // Box corners as seen by the model, indexed by register index.
    logic signed [31:0] box_corner [8];

    // Scoreboard: predicts the hit word of each ray and checks results in order.
    class SlabScoreboard;
        result_t pending_hits[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function longint clamp32(longint v);
            longint r;
            r = v;
            if (v > 64'sd2147483647) r = 64'sd2147483647;
            if (v < -64'sd2147483648) r = -64'sd2147483648;
            return r;
        endfunction

        static function longint recip(longint d);
            longint r;
            if (d == 0) r = 64'sd2147483647;
            else r = clamp32(64'sh1_0000_0000 / d);
            return r;
        endfunction

        // Product shifted down by 16 with floor rounding, then saturated.
        static function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return clamp32(p >>> 16);
        endfunction

        function void note_ray(ray_t r, longint lo[3], longint hi[3]);
            longint org[3];
            longint dir[3];
            longint ta, tb, t_in, t_out, inv, mn, mx;
            result_t e;
            org = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
            dir = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
            t_in = 0;
            t_out = 0;
            for (int a = 0; a < 3; a++) begin
                inv = recip(dir[a]);
                ta = qmul(clamp32(lo[a] - org[a]), inv);
                tb = qmul(clamp32(hi[a] - org[a]), inv);
                mn = (ta < tb) ? ta : tb;
                mx = (ta > tb) ? ta : tb;
                if (a == 0 || mn > t_in) t_in = mn;
                if (a == 0 || mx < t_out) t_out = mx;
            end
            if (t_out < 0 || t_in > t_out) begin
                e.hit = 1'b0;
                e.t_near = t_out[31:0];
                e.t_far = '0;
            end else begin
                e.hit = 1'b1;
                e.t_near = t_in[31:0];
                e.t_far = t_out[31:0];
            end
            pending_hits.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_hits.size() == 0) begin
                $error("Unexpected result word hit=%0b t_near=%0d t_far=%0d",
                       got.hit, got.t_near, got.t_far);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit: expected %0b, got %0b", e.hit, got.hit);
                errors++;
            end
            if (got.t_near !== e.t_near) begin
                $error("t_near: expected %0d, got %0d", e.t_near, got.t_near);
                errors++;
            end
            if (got.t_far !== e.t_far) begin
                $error("t_far: expected %0d, got %0d", e.t_far, got.t_far);
                errors++;
            end
        endfunction
    endclass

    SlabScoreboard board;

    ray_box_slab_test_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure except in stall_mode, check on every accepted word.
    logic stall_mode;
    int stall_left;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_mode) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Write one box register; the model copy updates at acceptance.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input q16_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        box_corner[idx] = val;
    endtask

    // Writes go back to back; valid drops after the last one.
    task automatic load_box(input q16_t mnx, mny, mnz, mxx, mxy, mxz);
        write_reg(REG_BOX_MIN_X, mnx);
        write_reg(REG_BOX_MIN_Y, mny);
        write_reg(REG_BOX_MIN_Z, mnz);
        write_reg(REG_BOX_MAX_X, mxx);
        write_reg(REG_BOX_MAX_Y, mxy);
        write_reg(REG_BOX_MAX_Z, mxz);
        cfg_valid <= 1'b0;
    endtask

    // After a random gap, offer one ray word, hold it until taken, then note it in the scoreboard.
    task automatic send_ray(input ray_t r);
        longint lo[3];
        longint hi[3];
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        for (int a = 0; a < 3; a++) begin
            lo[a] = box_corner[a];
            hi[a] = box_corner[a + 3];
        end
        board.note_ray(r, lo, hi);
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every expected word is back, then a little extra.
    task automatic drain();
        idle_sender();
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random Q16.16 value: mostly moderate, sometimes raw, zero or an extreme.
    function automatic q16_t rand_q(input int span);
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return q16_t'($urandom());
        if (p == 1) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        if (p == 2) return '0;
        return q16_t'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.origin_x = rand_q(32'h0020_0000);
        r.origin_y = rand_q(32'h0020_0000);
        r.origin_z = rand_q(32'h0020_0000);
        r.dir_x = rand_q(32'h0002_0000);
        r.dir_y = rand_q(32'h0002_0000);
        r.dir_z = rand_q(32'h0002_0000);
        return r;
    endfunction

    // Ray aimed from a random origin toward the box center, so many of them hit.
    function automatic ray_t aimed_ray();
        ray_t r;
        longint c;
        r = rand_ray();
        c = (longint'(box_corner[0]) + longint'(box_corner[3])) / 2;
        r.dir_x = q16_t'(c - longint'(r.origin_x)) >>> 4;
        c = (longint'(box_corner[1]) + longint'(box_corner[4])) / 2;
        r.dir_y = q16_t'(c - longint'(r.origin_y)) >>> 4;
        c = (longint'(box_corner[2]) + longint'(box_corner[5])) / 2;
        r.dir_z = q16_t'(c - longint'(r.origin_z)) >>> 4;
        return r;
    endfunction

    function automatic ray_t mk(input q16_t ox, oy, oz, dx, dy, dz);
        ray_t r;
        r = '{ox, oy, oz, dx, dy, dz};
        return r;
    endfunction

    localparam q16_t ONE = 32'sh0001_0000;

    initial begin
        ray_t r;
        board = new();
        cycles = 0;
        stall_mode = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_ready = 1'b0;
        for (int i = 0; i < 8; i++) box_corner[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A directed ray against the reset box (all corners zero).
        send_ray(mk(-ONE, 0, 0, ONE, 0, 0));
        drain();

        // Unit box, directed cases.
        load_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_ray(mk(-5 * ONE, 0, 0, ONE, 0, 0));          // axis-aligned hit
        send_ray(mk(-5 * ONE, 3 * ONE, 0, ONE, 0, 0));    // parallel miss
        send_ray(mk(5 * ONE, 0, 0, ONE, 0, 0));           // box behind the ray
        send_ray(mk(0, 0, 0, ONE, ONE, ONE));             // origin inside
        send_ray(mk(0, 0, 0, 0, 0, 0));                   // zero direction
        send_ray(mk(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_ray(mk(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_ray(mk(-ONE, -ONE, -ONE, 1, 1, 1));          // tiny direction
        send_ray(mk(-ONE, 0, 0, -1, 32'sh7FFF_0000, -ONE));
        send_ray(mk(2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE));
        send_ray(mk(-3 * ONE, -ONE, 0, ONE, 0, 0));       // grazing an edge
        send_ray(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        drain();

        // Extreme and inverted boxes.
        load_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_ray(mk(0, 0, 0, ONE, -ONE, 0));
        send_ray(mk(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0));
        for (int i = 0; i < 40; i++) send_ray(rand_ray());
        drain();
        load_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        send_ray(mk(0, 0, 0, ONE, ONE, ONE));
        for (int i = 0; i < 40; i++) send_ray(rand_ray());
        drain();

        // Random boxes, mostly rays aimed at them, some with no stalls.
        for (int phase = 0; phase < 8; phase++) begin
            load_box(rand_q(32'h0010_0000), rand_q(32'h0010_0000),
                     rand_q(32'h0010_0000), rand_q(32'h0010_0000),
                     rand_q(32'h0010_0000), rand_q(32'h0010_0000));
            stall_mode = (phase % 3 == 2);
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(0, 9) < 7) r = aimed_ray();
                else r = rand_ray();
                send_ray(r);
            end
            drain();
        end
        stall_mode = 1'b0;

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
